### hw/rtl/ult_pkg.sv
// Package for the unsorted list table: command codes, field widths,
// the result record and small width helpers.
// No dependencies; every other file of the block imports it.
package ult_pkg;

	localparam int DEPTH_DEF = 256;

	localparam int CMD_W   = 2;
	localparam int VALUE_W = 64;
	localparam int CAP_W   = 9;
	localparam int CMP_W   = 9;
	localparam int SHF_W   = 8;
	localparam int FILL_W  = 9;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	typedef struct packed {
		logic              ok;
		logic [CMP_W-1:0]  compare_count;
		logic [SHF_W-1:0]  shift_count;
		logic [FILL_W-1:0] fill_count;
	} res_t;

	function automatic logic [CMP_W-1:0] to_cmp(logic [31:0] v);
		return v[CMP_W-1:0];
	endfunction

	function automatic logic [SHF_W-1:0] to_shf(logic [31:0] v);
		return v[SHF_W-1:0];
	endfunction

	function automatic logic [FILL_W-1:0] to_fill(logic [31:0] v);
		return v[FILL_W-1:0];
	endfunction

endpackage

### hw/rtl/ult_if.sv
// Request and response channel interfaces of the unsorted list table.
// Depends on ult_pkg for the payload widths.
interface ult_req_if;
	import ult_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          cmd;
	logic signed [VALUE_W-1:0] value;
	modport source (output valid, cmd, value, input ready);
	modport sink (input valid, cmd, value, output ready);
endinterface

interface ult_rsp_if;
	import ult_pkg::*;
	logic              valid;
	logic              ready;
	logic              ok;
	logic [CMP_W-1:0]  compare_count;
	logic [SHF_W-1:0]  shift_count;
	logic [FILL_W-1:0] fill_count;
	modport source (output valid, ok, compare_count, shift_count, fill_count, input ready);
	modport sink (input valid, ok, compare_count, shift_count, fill_count, output ready);
endinterface

### hw/rtl/ult_mem.sv
// Entry store of the unsorted list table: one write port, one read port,
// registered read data. Depends on ult_pkg.
module ult_mem #(
	parameter int DEPTH = ult_pkg::DEPTH_DEF,
	parameter int AW    = 8
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [ult_pkg::VALUE_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [ult_pkg::VALUE_W-1:0] rdata
);
	import ult_pkg::*;

	logic [VALUE_W-1:0] entries_q [DEPTH];
	logic [VALUE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			entries_q[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= entries_q[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

### hw/rtl/ult_regs.sv
// APB-style configuration register file: capacity limit only.
// Depends on ult_pkg.
module ult_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ult_pkg::APB_AW-1:0] paddr,
	input  logic [ult_pkg::APB_DW-1:0] pwdata,
	output logic [ult_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output logic [ult_pkg::CAP_W-1:0]  capacity
);
	import ult_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (wr_en && paddr[2] == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_CAPACITY: prdata = {{(APB_DW-CAP_W){1'b0}}, cap_q};
			default:      prdata = '0;
		endcase
	end

	assign capacity = cap_q;

endmodule

### hw/rtl/ult_seq.sv
// Command sequencer: insert, scan, shift-down delete and clear over the
// entry store, plus the response register. Depends on ult_pkg, ult_if.
module ult_seq #(
	parameter int DEPTH = ult_pkg::DEPTH_DEF,
	parameter int AW    = 8,
	parameter int CW    = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ult_pkg::CAP_W-1:0]   capacity,
	ult_req_if.sink                     req,
	ult_rsp_if.source                   rsp,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [ult_pkg::VALUE_W-1:0] mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr,
	input  logic [ult_pkg::VALUE_W-1:0] mem_rdata
);
	import ult_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_HOLD  = 2'd3;

	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE     = CW'(1);
	localparam logic [CW-1:0] TWO     = CW'(2);

	logic [1:0]         state_q, state_d;
	logic [CW-1:0]      occ_q, occ_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic [CW-1:0]      cmp_q, cmp_d;
	logic [CW-1:0]      shf_q, shf_d;
	logic [VALUE_W-1:0] key_q, key_d;
	logic               del_q, del_d;
	logic               rsp_valid_q, rsp_valid_d;
	res_t               rsp_q, rsp_d;
	res_t               pend_q, pend_d;

	logic          accept, slot_free, fin, ins_ok, hit, last;
	logic [CW-1:0] idx_inc, idx_inc2, occ_dec, shf_inc;
	res_t          res;

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign idx_inc  = idx_q + ONE;
	assign idx_inc2 = idx_q + TWO;
	assign occ_dec  = occ_q - ONE;
	assign shf_inc  = shf_q + ONE;
	assign ins_ok   = (occ_q < DEPTH_C) && (32'(occ_q) < 32'(capacity));
	assign hit      = (mem_rdata == key_q);
	assign last     = (idx_inc == occ_q);

	always_comb begin
		state_d     = state_q;
		occ_d       = occ_q;
		idx_d       = idx_q;
		cmp_d       = cmp_q;
		shf_d       = shf_q;
		key_d       = key_q;
		del_d       = del_q;
		pend_d      = pend_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wdata   = '0;
		mem_re      = 1'b0;
		mem_raddr   = '0;
		fin         = 1'b0;
		res         = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.cmd) inside
						CMD_INSERT: begin
							fin = 1'b1;
							res.ok = ins_ok;
							if (ins_ok) begin
								mem_we    = 1'b1;
								mem_waddr = occ_q[AW-1:0];
								mem_wdata = req.value;
								occ_d     = occ_q + ONE;
							end
							res.fill_count = to_fill(32'(occ_d));
						end
						CMD_SEARCH, CMD_DELETE: begin
							key_d = req.value;
							del_d = (req.cmd == CMD_DELETE);
							if (occ_q == '0) begin
								fin            = 1'b1;
								res.fill_count = '0;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								idx_d     = '0;
								state_d   = S_SCAN;
							end
						end
						CMD_CLEAR: begin
							fin    = 1'b1;
							res.ok = 1'b1;
							occ_d  = '0;
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					cmp_d = idx_inc;
					if (!del_q) begin
						fin                = 1'b1;
						res.ok             = 1'b1;
						res.compare_count  = to_cmp(32'(idx_inc));
						res.fill_count     = to_fill(32'(occ_q));
					end else if (last) begin
						// match on the final entry: nothing to move
						fin                = 1'b1;
						res.ok             = 1'b1;
						res.compare_count  = to_cmp(32'(idx_inc));
						res.fill_count     = to_fill(32'(occ_dec));
						occ_d              = occ_dec;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = idx_inc[AW-1:0];
						shf_d     = '0;
						state_d   = S_SHIFT;
					end
				end else if (last) begin
					fin               = 1'b1;
					res.compare_count = to_cmp(32'(occ_q));
					res.fill_count    = to_fill(32'(occ_q));
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_inc[AW-1:0];
					idx_d     = idx_inc;
				end
			end
			S_SHIFT: begin
				// entry idx+1 is on the read port; move it down to idx
				mem_we    = 1'b1;
				mem_waddr = idx_q[AW-1:0];
				mem_wdata = mem_rdata;
				if (idx_inc2 == occ_q) begin
					fin               = 1'b1;
					res.ok            = 1'b1;
					res.compare_count = to_cmp(32'(cmp_q));
					res.shift_count   = to_shf(32'(shf_inc));
					res.fill_count    = to_fill(32'(occ_dec));
					occ_d             = occ_dec;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_inc2[AW-1:0];
					idx_d     = idx_inc;
					shf_d     = shf_inc;
				end
			end
			S_HOLD: begin
				if (slot_free) begin
					rsp_d       = pend_q;
					rsp_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (fin) begin
			if (slot_free) begin
				rsp_d       = res;
				rsp_valid_d = 1'b1;
				state_d     = S_IDLE;
			end else begin
				pend_d  = res;
				state_d = S_HOLD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			occ_q       <= occ_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		cmp_q  <= cmp_d;
		shf_q  <= shf_d;
		key_q  <= key_d;
		del_q  <= del_d;
		pend_q <= pend_d;
		rsp_q  <= rsp_d;
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.ok            = rsp_q.ok;
	assign rsp.compare_count = rsp_q.compare_count;
	assign rsp.shift_count   = rsp_q.shift_count;
	assign rsp.fill_count    = rsp_q.fill_count;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= DEPTH_C)
		else $error("fill beyond table depth");

	a_hold_has_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HOLD |-> rsp_valid_q)
		else $error("pending result without a waiting response");

	a_wr_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> CW'(mem_waddr) <= occ_q)
		else $error("write beyond fill");

	a_scan_no_wr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> !mem_we)
		else $error("store written during a scan");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.cmd == CMD_INSERT && ins_ok |=> occ_q == $past(occ_q) + ONE)
		else $error("insert did not grow the table");

endmodule

### hw/rtl/unsorted_list_table.sv
// Unsorted list table: an append-only table of signed 64-bit values with
// linear search, delete-with-shift and clear.
// Depends on ult_pkg, ult_if, ult_mem, ult_regs, ult_seq.
//
// Channels: req carries one command transaction (cmd, value); rsp returns
// exactly one result transaction per command (ok, compare_count,
// shift_count, fill_count). Both use valid/ready, taken when both high.
// capacity_limit sits behind the APB port at byte address 0; write it
// only while the table is idle.
//
// Timing: insert, clear and search/delete on an empty table finish in
// the accept cycle; the result is registered at the accepting edge when
// the response register is free. Other searches and deletes compare the
// entries one at a time through the single read port of the entry store
// and, for a delete that hits, then move each later entry down one place.
// Commands are processed one at a time; req.ready is high whenever the
// sequencer is idle, including while a finished result waits on rsp.
//
// Reset clears the fill count and sets the capacity to 256; the entry
// store is not cleared, since only entries below the fill are ever read.
// If rsp stalls, one more result is parked internally and req stays low
// until the response register frees.
module unsorted_list_table #(
	parameter int DEPTH = ult_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ult_req_if.sink                    req,
	ult_rsp_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ult_pkg::APB_AW-1:0] paddr,
	input  logic [ult_pkg::APB_DW-1:0] pwdata,
	output logic [ult_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import ult_pkg::*;

	// store address bits, and count bits able to hold DEPTH itself
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = ($clog2(DEPTH + 1) > 2) ? $clog2(DEPTH + 1) : 2;

	logic [CAP_W-1:0]   capacity;
	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [VALUE_W-1:0] mem_wdata, mem_rdata;

	ult_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	ult_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ult_seq #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

### tb/sv/unsorted_list_table_tb.sv
// Self-checking testbench for unsorted_list_table: a table of directed
// commands, then phases of random commands under several capacity settings.
// Depends on ult_pkg, ult_if and the unsorted_list_table RTL.
`timescale 1ns / 1ps

module unsorted_list_table_tb;
	import ult_pkg::*;

	localparam int DEPTH = DEPTH_DEF;

	// watchdog limit, set well above the length of the slowest correct run
	localparam int LIMIT_CYCLES = 3_000_000;
	// receiver hold-off used to back the table up into its request port
	localparam int LONG_HOLD = 400;
	// idle cycles after the last result before a register write or the end
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 2 * DEPTH + 8;

	localparam logic [APB_AW-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
	localparam int CAP_MASK = (1 << CAP_W) - 1;

	localparam logic signed [VALUE_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_ODD = 64'sh5555_5555_5555_5555;
	localparam logic signed [VALUE_W-1:0] VAL_EVN = 64'shAAAA_AAAA_AAAA_AAAA;
	localparam logic signed [VALUE_W-1:0] VAL_ONE = 64'sd1;
	localparam logic signed [VALUE_W-1:0] VAL_NEG = -64'sd1;
	localparam logic signed [VALUE_W-1:0] VAL_TOP = 64'sh8000_0000_0000_0001;

	// marks the phase whose capacity is drawn at random
	localparam int CAP_RANDOM = -1;
	localparam int PHASES     = 7;

	// one command transaction; want is used only where the row types it in
	typedef struct {
		logic [CMD_W-1:0]          cmd;
		logic signed [VALUE_W-1:0] value;
		bit                        typed;
		res_t                      want;
	} table_cmd_t;

	logic clk;
	logic arst_n;

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	ult_req_if req_ch ();
	ult_rsp_if rsp_ch ();

	unsorted_list_table #(
		.DEPTH(DEPTH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// ---------------------------------------------------------------
	// Mirror of the table, kept in step with every accepted command
	// ---------------------------------------------------------------
	logic signed [VALUE_W-1:0] tbl_mirror [DEPTH];
	int fill_mirror;
	int cap_mirror;

	// outcomes still owed by the block, oldest first
	res_t pending_outcomes [$];

	int mismatches;
	int cmds_sent;
	int results_seen;
	int caps_written;
	int peak_fill;
	int inserts_refused;
	int burst_left;
	int cycle_count;

	// capacity schedule for the random part: extremes, clamp case, random
	int phase_cap   [PHASES] = '{8, 0, 511, 1, CAP_RANDOM, 300, 256};
	int phase_items [PHASES] = '{120, 40, 320, 60, 100, 60, 100};
	// insert-heavy phase so the table reaches DEPTH and refuses inserts
	bit phase_fill  [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

	table_cmd_t directed_rows [$];

	// Works out what one command does to the mirror and what it reports.
	// Counts are truncated to the field widths, as the block does.
	function automatic res_t predict_outcome(input logic [CMD_W-1:0] op,
			input logic signed [VALUE_W-1:0] key);
		res_t r;
		int   n;
		int   pos;
		int   shifts;
		int   eff;
		r      = '0;
		n      = 0;
		pos    = -1;
		shifts = 0;
		// capacity above DEPTH behaves as DEPTH
		eff = (cap_mirror > DEPTH) ? DEPTH : cap_mirror;
		case (op) inside
			CMD_INSERT: begin
				if (fill_mirror < eff) begin
					tbl_mirror[fill_mirror] = key;
					fill_mirror++;
					r.ok = 1'b1;
				end else begin
					inserts_refused++;
				end
			end
			CMD_SEARCH, CMD_DELETE: begin
				// linear scan, stops at the first match
				for (int i = 0; i < fill_mirror && pos < 0; i++) begin
					n++;
					if (tbl_mirror[i] == key)
						pos = i;
				end
				if (pos >= 0) begin
					r.ok = 1'b1;
					if (op == CMD_DELETE) begin
						for (int i = pos; i + 1 < fill_mirror; i++) begin
							tbl_mirror[i] = tbl_mirror[i + 1];
							shifts++;
						end
						fill_mirror--;
					end
				end
			end
			CMD_CLEAR: begin
				fill_mirror = 0;
				r.ok        = 1'b1;
			end
			default: ;
		endcase
		if (fill_mirror > peak_fill)
			peak_fill = fill_mirror;
		r.compare_count = CMP_W'(n);
		r.shift_count   = SHF_W'(shifts);
		r.fill_count    = FILL_W'(fill_mirror);
		return r;
	endfunction

	function automatic table_cmd_t step_row(input logic [CMD_W-1:0] op,
			input logic signed [VALUE_W-1:0] v);
		table_cmd_t t;
		t.cmd   = op;
		t.value = v;
		t.typed = 1'b0;
		t.want  = '0;
		return t;
	endfunction

	// row whose outcome can be read straight off the command sequence
	function automatic table_cmd_t known_row(input logic [CMD_W-1:0] op,
			input logic signed [VALUE_W-1:0] v, input logic ok,
			input int cmp, input int shf, input int fill);
		table_cmd_t t;
		t       = step_row(op, v);
		t.typed = 1'b1;
		t.want  = '{ok: ok, compare_count: CMP_W'(cmp), shift_count: SHF_W'(shf),
			fill_count: FILL_W'(fill)};
		return t;
	endfunction

	// half full-width noise, plus small values that collide often,
	// the extremes, and walking single bits or their inverse
	function automatic logic signed [VALUE_W-1:0] random_value();
		logic signed [VALUE_W-1:0] v;
		int s;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = {$urandom, $urandom};
			5, 6, 7: begin
				s = $urandom_range(0, 8) - 4;
				v = 64'(s);
			end
			8: begin
				case ($urandom_range(0, 3))
					0:       v = VAL_MAX;
					1:       v = VAL_MIN;
					2:       v = '0;
					default: v = VAL_NEG;
				endcase
			end
			default: begin
				v = 64'sd1 <<< $urandom_range(0, 63);
				if ($urandom_range(0, 1) == 1)
					v = ~v;
			end
		endcase
		return v;
	endfunction

	// key taken from the table; front and back are favoured so that
	// full-length shifts and single compares turn up
	function automatic logic signed [VALUE_W-1:0] held_key();
		int idx;
		case ($urandom_range(0, 3))
			0:       idx = 0;
			1:       idx = fill_mirror - 1;
			default: idx = $urandom_range(0, fill_mirror - 1);
		endcase
		return tbl_mirror[idx];
	endfunction

	task automatic field_check(input string what, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Offers one command and returns at the edge where it is taken.
	// The sender works in bursts; between bursts valid may drop low.
	task automatic offer(input table_cmd_t it);
		int   gap;
		res_t got;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd   <= it.cmd;
		req_ch.value <= it.value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		burst_left--;
		cmds_sent++;
		// the mirror always moves; a typed row supplies its own expectation
		got = predict_outcome(it.cmd, it.value);
		pending_outcomes.push_back(it.typed ? it.want : got);
	endtask

	// stops offering and waits until every owed result has come back
	task automatic settle_table();
		req_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of capacity_limit, then a read back of the same register
	task automatic write_capacity(input int cap);
		logic [APB_DW-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CAP_ADDR;
		pwdata  <= APB_DW'(cap);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		cap_mirror = cap & CAP_MASK;
		caps_written++;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		field_check("capacity_limit read back", cap & CAP_MASK, rd[CAP_W-1:0]);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hang anywhere ends the run here
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still owed",
			cycle_count, pending_outcomes.size());
		$display("status: fail");
		$finish;
	end

	// ---------------------------------------------------------------
	// Result side: stalls on its own pattern, with two long hold-offs
	// so the parked result and then req.ready get exercised.
	// ---------------------------------------------------------------
	initial begin : result_sink
		int  style;
		int  style_left;
		int  taken;
		int  hold_left;
		int  last_hold_at;
		bit  rdy;
		rsp_ch.ready = 1'b0;
		style        = 0;
		style_left   = 0;
		taken        = 0;
		hold_left    = 0;
		last_hold_at = -1;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				taken++;
			if (hold_left == 0 && (taken == 30 || taken == 500) && taken != last_hold_at) begin
				hold_left    = LONG_HOLD;
				last_hold_at = taken;
			end
			if (style_left == 0) begin
				style      = $urandom_range(0, 3);
				style_left = $urandom_range(16, 96);
			end
			style_left--;
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (style)
					0:       rdy = 1'b1;                          // no stalls
					1:       rdy = ($urandom_range(0, 1) == 1);
					2:       rdy = ($urandom_range(0, 4) != 0);
					default: rdy = ($urandom_range(0, 4) == 0);   // mostly stalled
				endcase
			end
			rsp_ch.ready <= rdy;
		end
	end

	// Each result transaction is matched against the oldest owed outcome
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (pending_outcomes.size() == 0) begin
				$display("%0t: result %0d mismatch, expected none, actual fill %0d",
					$time, results_seen, rsp_ch.fill_count);
				mismatches++;
			end else begin
				res_t oldest;
				oldest = pending_outcomes.pop_front();
				field_check($sformatf("result %0d ok", results_seen),
					oldest.ok, rsp_ch.ok);
				field_check($sformatf("result %0d compare_count", results_seen),
					oldest.compare_count, rsp_ch.compare_count);
				field_check($sformatf("result %0d shift_count", results_seen),
					oldest.shift_count, rsp_ch.shift_count);
				field_check($sformatf("result %0d fill_count", results_seen),
					oldest.fill_count, rsp_ch.fill_count);
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin : stimulus
		table_cmd_t it;
		int         cap;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.cmd      = CMD_INSERT;
		req_ch.value    = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		fill_mirror     = 0;
		cap_mirror      = int'(CAP_RESET);
		mismatches      = 0;
		cmds_sent       = 0;
		results_seen    = 0;
		caps_written    = 0;
		peak_fill       = 0;
		inserts_refused = 0;
		burst_left      = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at the reset capacity. Table contents are tracked
		// in the comments where the outcome is typed in.
		// empty table: search and delete find nothing, clear still succeeds
		directed_rows.push_back(known_row(CMD_SEARCH, '0, 1'b0, 0, 0, 0));
		directed_rows.push_back(known_row(CMD_DELETE, '0, 1'b0, 0, 0, 0));
		directed_rows.push_back(known_row(CMD_CLEAR, VAL_NEG, 1'b1, 0, 0, 0));
		// fill with the extremes and a duplicate of the most negative value
		directed_rows.push_back(known_row(CMD_INSERT, VAL_MAX, 1'b1, 0, 0, 1));
		directed_rows.push_back(known_row(CMD_INSERT, VAL_MIN, 1'b1, 0, 0, 2));
		directed_rows.push_back(known_row(CMD_INSERT, VAL_NEG, 1'b1, 0, 0, 3));
		directed_rows.push_back(known_row(CMD_INSERT, '0, 1'b1, 0, 0, 4));
		directed_rows.push_back(known_row(CMD_INSERT, VAL_MIN, 1'b1, 0, 0, 5));
		directed_rows.push_back(known_row(CMD_INSERT, VAL_ODD, 1'b1, 0, 0, 6));
		directed_rows.push_back(known_row(CMD_INSERT, VAL_EVN, 1'b1, 0, 0, 7));
		// [MAX MIN -1 0 MIN 55.. AA..]: first hit, first duplicate, last, miss
		directed_rows.push_back(known_row(CMD_SEARCH, VAL_MAX, 1'b1, 1, 0, 7));
		directed_rows.push_back(known_row(CMD_SEARCH, VAL_MIN, 1'b1, 2, 0, 7));
		directed_rows.push_back(known_row(CMD_SEARCH, VAL_EVN, 1'b1, 7, 0, 7));
		directed_rows.push_back(known_row(CMD_SEARCH, VAL_ONE, 1'b0, 7, 0, 7));
		directed_rows.push_back(known_row(CMD_DELETE, VAL_ONE, 1'b0, 7, 0, 7));
		// delete of the first duplicate moves the five later entries down
		directed_rows.push_back(known_row(CMD_DELETE, VAL_MIN, 1'b1, 2, 5, 6));
		directed_rows.push_back(step_row(CMD_SEARCH, VAL_MIN));
		directed_rows.push_back(step_row(CMD_DELETE, VAL_EVN));
		directed_rows.push_back(step_row(CMD_DELETE, VAL_MAX));
		directed_rows.push_back(step_row(CMD_INSERT, VAL_ONE));
		directed_rows.push_back(known_row(CMD_CLEAR, VAL_ODD, 1'b1, 0, 0, 0));
		directed_rows.push_back(known_row(CMD_SEARCH, VAL_NEG, 1'b0, 0, 0, 0));
		directed_rows.push_back(known_row(CMD_INSERT, VAL_TOP, 1'b1, 0, 0, 1));
		directed_rows.push_back(known_row(CMD_DELETE, VAL_TOP, 1'b1, 1, 0, 0));

		foreach (directed_rows[i])
			offer(directed_rows[i]);

		// Random part. Capacity changes only with the table idle; the table
		// is not cleared between phases, so a lowered capacity can sit
		// below the fill.
		for (int p = 0; p < PHASES; p++) begin
			settle_table();
			cap = (phase_cap[p] == CAP_RANDOM) ? $urandom_range(2, 64) : phase_cap[p];
			write_capacity(cap);
			for (int k = 0; k < phase_items[p]; k++) begin
				int r;
				r        = $urandom_range(0, 99);
				it.typed = 1'b0;
				it.want  = '0;
				if (phase_fill[p])
					it.cmd = (r < 88) ? CMD_INSERT : (r < 94) ? CMD_SEARCH : CMD_DELETE;
				else
					it.cmd = (r < 45) ? CMD_INSERT : (r < 70) ? CMD_SEARCH :
						(r < 96) ? CMD_DELETE : CMD_CLEAR;
				// most lookups use a key that is in the table
				if (it.cmd == CMD_INSERT || fill_mirror == 0 || $urandom_range(0, 9) >= 7)
					it.value = random_value();
				else
					it.value = held_key();
				offer(it);
			end
		end

		settle_table();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d commands (%0d directed) across %0d capacity writes, %0d results",
			cmds_sent, directed_rows.size(), caps_written, results_seen);
		$display("table peaked at %0d of %0d entries, %0d inserts refused, %0d mismatches",
			peak_fill, DEPTH, inserts_refused, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
